// ===== hdl/sfsd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfsd_pkg
// shared constants and the noise generator step of the sine fold saturator
// ----------------------------------------------------------------------------
`default_nettype none

package sfsd_pkg;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_LEFT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_RIGHT = 1'b1;

  localparam logic [31:0] SEED_LEFT_RST  = 32'd16386;
  localparam logic [31:0] SEED_RIGHT_RST = 32'd16387;

  // pi/2 in Q.56, truncated
  localparam logic [63:0] HALF_PI_Q56 = 64'h01921FB54442D184;
  localparam logic [33:0] DITHER_MID  = 34'h07fffffff;

  typedef logic [31:0] noise_t;

  function automatic noise_t xs_next(input noise_t s);
    noise_t x;
    x = s ^ (s << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sfsd_mul.sv =====
// ----------------------------------------------------------------------------
// sfsd_mul
// bit-serial 32x32 unsigned multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sfsd_mul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             done,
  output logic [63:0]      p
);

  logic [63:0] acc_r;
  logic [31:0] mcand_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] part;

  assign part = {1'b0, acc_r[63:32]} + (acc_r[0] ? {1'b0, mcand_r} : 33'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == 5'd0);
      if (start) begin
        acc_r   <= {32'd0, b};
        mcand_r <= a;
        cnt_r   <= 5'd31;
        busy_r  <= 1'b1;
      end else if (busy_r) begin
        acc_r <= {part, acc_r[31:1]};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

`default_nettype wire

// ===== hdl/sfsd_div.sv =====
// ----------------------------------------------------------------------------
// sfsd_div
// restoring 64-bit unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sfsd_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] n,
  input  wire logic [63:0] d,
  output logic             done,
  output logic [63:0]      quo,
  output logic [63:0]      rem
);

  logic [64:0] rem_r;
  logic [63:0] quo_r;
  logic [63:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [64:0] trial;
  logic        fits;

  assign trial = {rem_r[63:0], quo_r[63]};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == 6'd0);
      if (start) begin
        quo_r  <= n;
        rem_r  <= '0;
        den_r  <= d;
        cnt_r  <= 6'd63;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? (trial - {1'b0, den_r}) : trial;
        quo_r <= {quo_r[62:0], fits};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r[63:0];

endmodule

`default_nettype wire

// ===== hdl/sfsd_chan.sv =====
// ----------------------------------------------------------------------------
// sfsd_chan
// one-channel sequencer: sine fold through serial multiply and divide,
// serial exponent search and serial dither scaling
// ----------------------------------------------------------------------------
`default_nettype none

module sfsd_chan import sfsd_pkg::*; #(
  parameter int IN_WIDTH        = 24,
  parameter int OUT_WIDTH       = 32,
  parameter int SINE_ITERATIONS = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic signed [IN_WIDTH-1:0]  sample,
  input  wire noise_t                      noise,
  output logic                             done,
  output logic signed [OUT_WIDTH-1:0]      result
);

  localparam int KW      = $clog2(SINE_ITERATIONS);
  localparam int YW      = OUT_WIDTH + 2;
  localparam int SW      = ((YW > 34) ? YW : 34) + 1;
  localparam int SH_ZERO = 56 - OUT_WIDTH;
  localparam int SH_BASE = 87 - OUT_WIDTH;

  localparam logic signed [SW-1:0] ONE    = 1;
  localparam logic signed [SW-1:0] SUM_HI = (ONE <<< (OUT_WIDTH - 1)) - ONE;
  localparam logic signed [SW-1:0] SUM_LO = -SUM_HI - ONE;

  localparam logic [3:0] C_IDLE = 4'd0;
  localparam logic [3:0] C_T    = 4'd1;
  localparam logic [3:0] C_Q    = 4'd2;
  localparam logic [3:0] C_U2   = 4'd3;
  localparam logic [3:0] C_SM   = 4'd4;
  localparam logic [3:0] C_SD   = 4'd5;
  localparam logic [3:0] C_FIN  = 4'd6;
  localparam logic [3:0] C_LEN  = 4'd7;
  localparam logic [3:0] C_DSH  = 4'd8;

  logic [3:0]              state_r, state_nxt;
  logic                    neg_r, neg_nxt;
  logic [31:0]             a28_r, a28_nxt;
  logic [63:0]             t_r, t_nxt;
  logic                    qz_r, qz_nxt;
  logic                    q1_r, q1_nxt;
  logic [31:0]             op_r, op_nxt;
  logic [31:0]             u2_r, u2_nxt;
  logic [31:0]             term_r, term_nxt;
  logic signed [33:0]      sum_r, sum_nxt;
  logic [KW-1:0]           k_r, k_nxt;
  logic [31:0]             mag_r, mag_nxt;
  logic [31:0]             shw_r, shw_nxt;
  logic [5:0]              len_r, len_nxt;
  logic signed [33:0]      vv_r, vv_nxt;
  logic [5:0]              cnt_r, cnt_nxt;
  logic                    mul_go_r, mul_go_nxt;
  logic                    div_go_r, div_go_nxt;
  logic                    done_r, done_nxt;
  logic [OUT_WIDTH-1:0]    res_r, res_nxt;

  logic [IN_WIDTH-1:0]     a_abs;
  logic [31:0]             mul_a, mul_b;
  logic [63:0]             div_n, div_d;
  logic                    mul_done, div_done;
  logic [63:0]             mul_p, div_quo, div_rem;
  logic [2*KW+1:0]         den;
  logic [63:0]             v;
  logic [5:0]              sh;
  logic signed [33:0]      diff;
  logic [YW-1:0]           ymag;
  logic signed [YW-1:0]    y;
  logic signed [SW-1:0]    sumw;
  logic                    fneg;

  assign a_abs = sample[IN_WIDTH-1] ? IN_WIDTH'(-sample) : IN_WIDTH'(sample);
  assign den   = {k_r, 1'b0} * {k_r, 1'b1};
  assign diff  = $signed({2'b00, noise}) - $signed(DITHER_MID);

  always_comb begin
    case (state_r)
      C_T: begin
        mul_a = a28_r;
        mul_b = a28_r;
      end
      C_U2: begin
        mul_a = op_r;
        mul_b = op_r;
      end
      C_SM: begin
        mul_a = term_r;
        mul_b = u2_r;
      end
      default: begin
        mul_a = a28_r;
        mul_b = op_r;
      end
    endcase
  end

  always_comb begin
    case (state_r)
      C_Q: begin
        div_n = t_r;
        div_d = HALF_PI_Q56;
      end
      C_SD: begin
        div_n = mul_p >> 30;
        div_d = 64'(den);
      end
      default: begin
        div_n = 64'({op_r, 29'd0}) + (64'(a28_r) >> 1);
        div_d = 64'(a28_r);
      end
    endcase
  end

  sfsd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go_r),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  sfsd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .n     (div_n),
    .d     (div_d),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  generate
    if (OUT_WIDTH >= 32) begin : g_wide
      assign ymag = YW'(mag_r) << (OUT_WIDTH - 32);
    end else begin : g_narrow
      logic [32:0] rnd;
      assign rnd  = {1'b0, mag_r} + (33'd1 << (31 - OUT_WIDTH));
      assign ymag = YW'(rnd >> (32 - OUT_WIDTH));
    end
  endgenerate

  assign fneg = neg_r ^ (!qz_r & q1_r);
  assign y    = fneg ? -$signed(ymag) : $signed(ymag);
  assign sumw = SW'(y) + SW'(vv_r);
  assign sh   = (mag_r == 32'd0) ? 6'(SH_ZERO) : (6'(SH_BASE) - len_r);
  assign v    = div_quo[0] ? (HALF_PI_Q56 - div_rem) : div_rem;

  always_comb begin
    state_nxt  = state_r;
    neg_nxt    = neg_r;
    a28_nxt    = a28_r;
    t_nxt      = t_r;
    qz_nxt     = qz_r;
    q1_nxt     = q1_r;
    op_nxt     = op_r;
    u2_nxt     = u2_r;
    term_nxt   = term_r;
    sum_nxt    = sum_r;
    k_nxt      = k_r;
    mag_nxt    = mag_r;
    shw_nxt    = shw_r;
    len_nxt    = len_r;
    vv_nxt     = vv_r;
    cnt_nxt    = cnt_r;
    res_nxt    = res_r;
    mul_go_nxt = 1'b0;
    div_go_nxt = 1'b0;
    done_nxt   = 1'b0;
    case (state_r)
      C_IDLE: begin
        if (start) begin
          neg_nxt    = sample[IN_WIDTH-1];
          a28_nxt    = 32'(a_abs) << (32 - IN_WIDTH);
          mul_go_nxt = 1'b1;
          state_nxt  = C_T;
        end
      end
      C_T: begin
        if (mul_done) begin
          t_nxt      = mul_p;
          div_go_nxt = 1'b1;
          state_nxt  = C_Q;
        end
      end
      C_Q: begin
        if (div_done) begin
          qz_nxt = (div_quo == 64'd0);
          q1_nxt = div_quo[1];
          if (div_quo == 64'd0) begin
            op_nxt   = 32'(t_r >> 26);
            term_nxt = 32'd1 << 30;
          end else begin
            op_nxt   = 32'(v >> 26);
            term_nxt = 32'(v >> 26);
          end
          mul_go_nxt = 1'b1;
          state_nxt  = C_U2;
        end
      end
      C_U2: begin
        if (mul_done) begin
          u2_nxt     = 32'(mul_p >> 30);
          sum_nxt    = $signed({2'b00, term_r});
          k_nxt      = KW'(1);
          mul_go_nxt = 1'b1;
          state_nxt  = C_SM;
        end
      end
      C_SM: begin
        if (mul_done) begin
          div_go_nxt = 1'b1;
          state_nxt  = C_SD;
        end
      end
      C_SD: begin
        if (div_done) begin
          term_nxt = div_quo[31:0];
          sum_nxt  = k_r[0] ? (sum_r - $signed({2'b00, div_quo[31:0]}))
                            : (sum_r + $signed({2'b00, div_quo[31:0]}));
          if (k_r == KW'(SINE_ITERATIONS - 1)) begin
            op_nxt    = sum_nxt[33] ? 32'd0 : sum_nxt[31:0];
            state_nxt = C_FIN;
            if (qz_r) begin
              mul_go_nxt = 1'b1;
            end else begin
              div_go_nxt = 1'b1;
            end
          end else begin
            k_nxt      = k_r + KW'(1);
            mul_go_nxt = 1'b1;
            state_nxt  = C_SM;
          end
        end
      end
      C_FIN: begin
        if (qz_r ? mul_done : div_done) begin
          mag_nxt   = qz_r ? 32'(mul_p >> 27) : div_quo[31:0];
          shw_nxt   = qz_r ? 32'(mul_p >> 27) : div_quo[31:0];
          len_nxt   = '0;
          state_nxt = C_LEN;
        end
      end
      C_LEN: begin
        if (shw_r != 32'd0) begin
          shw_nxt = shw_r >> 1;
          len_nxt = len_r + 6'd1;
        end else begin
          if (sh >= 6'd33) begin
            vv_nxt  = '0;
            cnt_nxt = '0;
          end else begin
            vv_nxt  = diff + $signed(34'd1 << (sh - 6'd1));
            cnt_nxt = sh;
          end
          state_nxt = C_DSH;
        end
      end
      C_DSH: begin
        if (cnt_r != 6'd0) begin
          vv_nxt  = vv_r >>> 1;
          cnt_nxt = cnt_r - 6'd1;
        end else begin
          if (sumw > SUM_HI) begin
            res_nxt = OUT_WIDTH'(SUM_HI);
          end else if (sumw < SUM_LO) begin
            res_nxt = OUT_WIDTH'(SUM_LO);
          end else begin
            res_nxt = OUT_WIDTH'(sumw);
          end
          done_nxt  = 1'b1;
          state_nxt = C_IDLE;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= C_IDLE;
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mul_go_r <= mul_go_nxt;
      div_go_r <= div_go_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    a28_r  <= a28_nxt;
    t_r    <= t_nxt;
    qz_r   <= qz_nxt;
    q1_r   <= q1_nxt;
    op_r   <= op_nxt;
    u2_r   <= u2_nxt;
    term_r <= term_nxt;
    sum_r  <= sum_nxt;
    k_r    <= k_nxt;
    mag_r  <= mag_nxt;
    shw_r  <= shw_nxt;
    len_r  <= len_nxt;
    vv_r   <= vv_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  assign done   = done_r;
  assign result = $signed(res_r);

endmodule

`default_nettype wire

// ===== hdl/sine_fold_saturator_with_dither_core.sv =====
// ----------------------------------------------------------------------------
// sine_fold_saturator_with_dither_core
// stereo sine fold saturator with per-channel xorshift32 dither
//
//   channel  ports                                   handshake
//   input    in_sample_left, in_sample_right         in_valid / in_stall
//   output   out_left, out_right                     out_valid / out_stall
//   config   cfg_index, cfg_data                     cfg_valid / cfg_ready
//
// one word runs a SINE_ITERATIONS-term series per channel through the one
// shared channel sequencer, left channel first, then right; each series term
// after the first is a serial multiply and a serial divide
// a finished word waits in the output register while the next one is taken
// reset loads both noise generators with their default seeds
// ----------------------------------------------------------------------------
`default_nettype none

module sine_fold_saturator_with_dither_core import sfsd_pkg::*; #(
  parameter int IN_WIDTH        = 24,
  parameter int OUT_WIDTH       = 32,
  parameter int SINE_ITERATIONS = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [IN_WIDTH-1:0]  in_sample_left,
  input  wire logic signed [IN_WIDTH-1:0]  in_sample_right,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [OUT_WIDTH-1:0]      out_left,
  output logic signed [OUT_WIDTH-1:0]      out_right,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [31:0]                 cfg_data
);

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_LEFT  = 2'd1;
  localparam logic [1:0] T_RIGHT = 2'd2;
  localparam logic [1:0] T_HOLD  = 2'd3;

  logic [1:0]                  tst_r;
  logic                        go_r;
  logic                        ov_r;
  noise_t                      noise_l_r, noise_r_r;
  logic signed [IN_WIDTH-1:0]  smp_l_r, smp_r_r;
  logic signed [OUT_WIDTH-1:0] resl_r, resr_r;
  logic signed [OUT_WIDTH-1:0] outl_r, outr_r;

  logic                        ch_done;
  logic signed [OUT_WIDTH-1:0] ch_res;
  logic signed [IN_WIDTH-1:0]  ch_smp;
  noise_t                      ch_noise;

  assign ch_smp   = (tst_r == T_RIGHT) ? smp_r_r : smp_l_r;
  assign ch_noise = (tst_r == T_RIGHT) ? noise_r_r : noise_l_r;

  sfsd_chan #(
    .IN_WIDTH        (IN_WIDTH),
    .OUT_WIDTH       (OUT_WIDTH),
    .SINE_ITERATIONS (SINE_ITERATIONS)
  ) u_chan (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (go_r),
    .sample (ch_smp),
    .noise  (ch_noise),
    .done   (ch_done),
    .result (ch_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tst_r     <= T_IDLE;
      go_r      <= 1'b0;
      ov_r      <= 1'b0;
      noise_l_r <= SEED_LEFT_RST;
      noise_r_r <= SEED_RIGHT_RST;
    end else begin
      go_r <= ((tst_r == T_IDLE) && in_valid) || ((tst_r == T_LEFT) && ch_done);
      if (ov_r && !out_stall && (tst_r != T_HOLD)) begin
        ov_r <= 1'b0;
      end
      case (tst_r)
        T_IDLE: begin
          if (in_valid) begin
            smp_l_r   <= in_sample_left;
            smp_r_r   <= in_sample_right;
            noise_l_r <= xs_next(noise_l_r);
            noise_r_r <= xs_next(noise_r_r);
            tst_r     <= T_LEFT;
          end
        end
        T_LEFT: begin
          if (ch_done) begin
            resl_r <= ch_res;
            tst_r  <= T_RIGHT;
          end
        end
        T_RIGHT: begin
          if (ch_done) begin
            resr_r <= ch_res;
            tst_r  <= T_HOLD;
          end
        end
        T_HOLD: begin
          if (!ov_r || !out_stall) begin
            outl_r <= resl_r;
            outr_r <= resr_r;
            ov_r   <= 1'b1;
            tst_r  <= T_IDLE;
          end
        end
        default: begin
          tst_r <= T_IDLE;
        end
      endcase
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SEED_LEFT:  noise_l_r <= cfg_data;
          CFG_SEED_RIGHT: noise_r_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  assign in_stall  = (tst_r != T_IDLE);
  assign out_valid = ov_r;
  assign out_left  = outl_r;
  assign out_right = outr_r;
  assign cfg_ready = (tst_r == T_IDLE) && !in_valid;

endmodule

`default_nettype wire
